>>> src/esc_pkg.sv
`timescale 1ns / 1ps
package esc_pkg;
  localparam int unsigned DAYS_W = 16;
  localparam logic [7:0] EPOCH_YEAR_OFS = 8'd70;

  // days before each month start in a common year
  function automatic logic [8:0] month_start(input logic [3:0] m);
    case (m)
      4'd0: month_start = 9'd0;
      4'd1: month_start = 9'd31;
      4'd2: month_start = 9'd59;
      4'd3: month_start = 9'd90;
      4'd4: month_start = 9'd120;
      4'd5: month_start = 9'd151;
      4'd6: month_start = 9'd181;
      4'd7: month_start = 9'd212;
      4'd8: month_start = 9'd243;
      4'd9: month_start = 9'd273;
      4'd10: month_start = 9'd304;
      4'd11: month_start = 9'd334;
      default: month_start = 9'd0;
    endcase
  endfunction

  // calendar year 1900+y is leap; 2000 is leap, 2100 is not
  function automatic logic is_leap(input logic [7:0] y);
    is_leap = (y[1:0] == 2'b00) && (y != 8'd200);
  endfunction

  // days from 1970-01-01 to 1 january of year 1900+y (y >= 70)
  function automatic logic [DAYS_W-1:0] year_start(input logic [7:0] y);
    logic [7:0] n;
    logic [7:0] leaps;
    logic [23:0] d;
    n = y - EPOCH_YEAR_OFS;
    leaps = (n + 8'd1) >> 2;
    if (y > 8'd200) leaps = leaps - 8'd1;
    d = 24'(n) * 24'd365 + 24'(leaps);
    year_start = d[DAYS_W-1:0];
  endfunction
endpackage

>>> src/esc_divmod.sv
`timescale 1ns / 1ps
// registered split of a value into quotient and remainder by a constant,
// through a reciprocal multiply and one correction
module esc_divmod #(
  parameter int unsigned IN_W = 32,
  parameter int unsigned Q_W = 26,
  parameter int unsigned R_W = 6,
  parameter int unsigned DIVISOR = 60
) (
  input  logic clk,
  input  logic en,
  input  logic [IN_W-1:0] num,
  output logic [Q_W-1:0] quo,
  output logic [R_W-1:0] rem
);
  localparam int unsigned SH = IN_W + 6;
  localparam int unsigned P_W = IN_W + SH + 1;
  localparam logic [SH:0] RECIP = (SH+1)'(((64'd1 << SH) / DIVISOR));
  logic [P_W-1:0] prod;
  logic [IN_W-1:0] q0;
  logic [IN_W-1:0] r0;
  logic fix;
  always_comb begin
    prod = P_W'(num) * P_W'(RECIP);
    q0 = IN_W'(prod >> SH);
    r0 = num - IN_W'(q0 * IN_W'(DIVISOR));
    fix = r0 >= IN_W'(DIVISOR);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      quo <= fix ? Q_W'(q0 + 1'b1) : Q_W'(q0);
      rem <= fix ? R_W'(r0 - IN_W'(DIVISOR)) : R_W'(r0);
    end
  end
endmodule

>>> src/epoch_seconds_to_calendar_unit.sv
`timescale 1ns / 1ps
// channel  | dir | payload
// s_axis   | in  | tdata[31:0] epoch_seconds
// m_axis   | out | tdata[45:0] second..day_of_month
// six-stage pipeline, one transaction a cycle while m_axis is not stalled
// stage 1 seconds/60, 2 minutes/60, 3 hours/24, 4 days/7 and year estimate,
// 5 year correction, 6 month lookup
// rst clears the valid bits only; a stall holds every stage
module epoch_seconds_to_calendar_unit (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [31:0] s_axis_tdata, // [31:0] epoch_seconds
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // [5:0] second, [11:6] minute, [16:12] hour, [19:17] weekday,
  // [27:20] years_since_1900, [36:28] day_of_year, [40:37] month,
  // [45:41] day_of_month, [47:46] zero
  output logic [47:0] m_axis_tdata
);
  import esc_pkg::*;

  localparam int unsigned NST = 6;
  logic [NST-1:0] vld;
  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NST-2:0], s_axis_tvalid};
  end

  logic [26:0] mins1; logic [5:0] sec1;
  logic [20:0] hrs2; logic [5:0] min2; logic [5:0] sec2;
  logic [15:0] days3; logic [4:0] hr3; logic [5:0] min3; logic [5:0] sec3;
  logic [12:0] wk4; logic [2:0] wd4;

  esc_divmod #(.IN_W(32), .Q_W(27), .R_W(6), .DIVISOR(60)) u_s
    (.clk, .en(adv), .num(s_axis_tdata), .quo(mins1), .rem(sec1));
  esc_divmod #(.IN_W(27), .Q_W(21), .R_W(6), .DIVISOR(60)) u_m
    (.clk, .en(adv), .num(mins1), .quo(hrs2), .rem(min2));
  esc_divmod #(.IN_W(21), .Q_W(16), .R_W(5), .DIVISOR(24)) u_h
    (.clk, .en(adv), .num(hrs2), .quo(days3), .rem(hr3));
  esc_divmod #(.IN_W(16), .Q_W(13), .R_W(3), .DIVISOR(7)) u_w
    (.clk, .en(adv), .num(16'(days3 + 16'd4)), .quo(wk4), .rem(wd4));

  // year estimate from days*2^20/365.25, may be one high
  logic [15:0] days4; logic [4:0] hr4; logic [5:0] min4; logic [5:0] sec4;
  logic [7:0] yest4;
  logic [35:0] yprod;
  assign yprod = 36'(days3) * 36'd2871 + 36'd2871;
  always_ff @(posedge clk) begin
    if (adv) begin
      sec2 <= sec1;
      min3 <= min2; sec3 <= sec2;
      days4 <= days3; hr4 <= hr3; min4 <= min3; sec4 <= sec3;
      yest4 <= 8'(yprod >> 20) + EPOCH_YEAR_OFS;
    end
  end

  logic [7:0] year5; logic [8:0] doy5; logic [2:0] wd5;
  logic [4:0] hr5; logic [5:0] min5; logic [5:0] sec5;
  logic [15:0] ys4;
  logic over4;
  always_comb begin
    ys4 = year_start(yest4);
    over4 = ys4 > days4;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      year5 <= over4 ? yest4 - 8'd1 : yest4;
      doy5 <= over4 ? 9'(days4 - year_start(yest4 - 8'd1)) : 9'(days4 - ys4);
      wd5 <= wd4; hr5 <= hr4; min5 <= min4; sec5 <= sec4;
    end
  end

  logic [3:0] mon;
  logic [8:0] mstart;
  logic lp;
  always_comb begin
    logic [8:0] s;
    lp = is_leap(year5);
    mon = 4'd0;
    mstart = 9'd0;
    for (int m = 1; m < 12; m++) begin
      s = month_start(4'(m)) + ((lp && m >= 2) ? 9'd1 : 9'd0);
      if (doy5 >= s) begin
        mon = 4'(m);
        mstart = s;
      end
    end
  end

  logic [8:0] dom_full;
  assign dom_full = doy5 - mstart + 9'd1;
  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {2'b00, dom_full[4:0], mon, doy5, year5, wd5, hr5, min5, sec5};
    end
  end
endmodule

>>> src/esc_checker.sv
`timescale 1ns / 1ps
module esc_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[5:0] < 6'd60 && m_axis_tdata[11:6] < 6'd60
      && m_axis_tdata[16:12] < 5'd24 && m_axis_tdata[19:17] < 3'd7
      && m_axis_tdata[40:37] < 4'd12 && m_axis_tdata[45:41] != 5'd0)
    else $error("field out of range");
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("valid after reset");
endmodule

bind epoch_seconds_to_calendar_unit esc_checker u_esc_checker (.*);
